// ----- design/sha_pkg.sv -----
package sha_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned WORDS      = 8;
    localparam int unsigned BLK_BITS   = 512;
    localparam logic [7:0]  PAD_MARK   = 8'h80;
    localparam logic [5:0]  LEN_START  = 6'd56;

    // Initial hash value H0..H7
    function automatic t_word init_hash(input logic [2:0] idx);
        t_word r;
        case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            3'd7: r = 32'h5be0cd19;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    // Round constants
    function automatic t_word round_k(input logic [5:0] idx);
        t_word r;
        case (idx)
            6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic t_word big_sig0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sig1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word sml_sig0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word sml_sig1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ----- design/sha256_message_hasher_top.sv -----
// Byte transactions are taken one per cycle while a block is filling.
// A full 64-byte block stalls the input while its rounds run on the
// single shared round unit and the result is folded into the chained hash.
// End of message: pad bytes fill the block before it is compressed, and a second block follows when the
// length spills into a second block; the last fold waits until the digest register is free.
// Synchronous active-low reset loads the initial hash and clears all counters.
module sha256_message_hasher_top
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word_0,
    output logic [31:0] o_digest_word_1,
    output logic [31:0] o_digest_word_2,
    output logic [31:0] o_digest_word_3,
    output logic [31:0] o_digest_word_4,
    output logic [31:0] o_digest_word_5,
    output logic [31:0] o_digest_word_6,
    output logic [31:0] o_digest_word_7
);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;  // take byte transactions
    localparam logic [1:0] ST_PAD  = 2'd1;  // shift in 0x80, zeros, length
    localparam logic [1:0] ST_RND  = 2'd2;  // one compression round a cycle
    localparam logic [1:0] ST_ADD  = 2'd3;  // fold working vars into hash

    logic [1:0]          r_state, n_state;
    logic [5:0]          r_fill, n_fill;      // bytes in the current block
    logic [5:0]          r_rnd, n_rnd;        // round index
    logic [63:0]         r_bits, n_bits;      // message length in bits
    logic                r_end_pend, n_end_pend;  // message end seen
    logic                r_padding, n_padding;    // padding has started
    logic                r_pad_first, n_pad_first; // next pad byte is 0x80
    logic                r_final, n_final;    // this block carries the length
    logic                r_out_valid, n_out_valid;
    t_word               r_hash [WORDS];
    t_word               n_hash [WORDS];

    // The block buffer doubles as the 16-word message schedule window:
    // word 0 sits in the top 32 bits, bytes shift in at the bottom.
    logic [BLK_BITS-1:0] r_blk;
    t_word               r_v   [WORDS];       // working variables a..h
    t_word               r_dig [WORDS];

    logic                in_acc;
    logic                out_acc;
    logic [7:0]          pad_byte;
    logic                blk_shift_byte;
    logic [7:0]          shift_byte;
    logic                load_v;
    logic                do_round;
    logic                out_load;
    t_word               sum   [WORDS];
    t_word               w_new;
    t_word               t1;
    t_word               t2;
    t_word               ch;
    t_word               maj;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = r_out_valid && i_ready;
    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;

    // Schedule: W[t+16] = s1(W[t+14]) + W[t+9] + s0(W[t+1]) + W[t]
    assign w_new = sml_sig1(r_blk[63:32]) + r_blk[223:192]
                 + sml_sig0(r_blk[479:448]) + r_blk[511:480];

    // Shared round unit
    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1  = r_v[7] + big_sig1(r_v[4]) + ch + round_k(r_rnd) + r_blk[511:480];
    assign t2  = big_sig0(r_v[0]) + maj;

    always_comb begin
        for (int i = 0; i < WORDS; i++) begin
            sum[i] = r_hash[i] + r_v[i];
        end
    end

    // Padding byte: 0x80 marker, then zeros, then the big-endian bit count
    always_comb begin
        if (r_pad_first) begin
            pad_byte = PAD_MARK;
        end else if (r_final && (r_fill >= LEN_START)) begin
            pad_byte = r_bits[{~r_fill[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_rnd       = r_rnd;
        n_bits      = r_bits;
        n_end_pend  = r_end_pend;
        n_padding   = r_padding;
        n_pad_first = r_pad_first;
        n_final     = r_final;
        n_out_valid = r_out_valid;
        for (int i = 0; i < WORDS; i++) begin
            n_hash[i] = r_hash[i];
        end
        blk_shift_byte = 1'b0;
        shift_byte     = i_data_byte;
        load_v         = 1'b0;
        do_round       = 1'b0;
        out_load       = 1'b0;

        if (out_acc) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_has_byte) begin
                        blk_shift_byte = 1'b1;
                        n_fill = r_fill + 6'd1;
                        n_bits = r_bits + 64'd8;
                    end
                    if (i_has_byte && (r_fill == 6'd63)) begin
                        // block full: compress first, pad afterward if ending
                        n_state    = ST_RND;
                        n_rnd      = '0;
                        load_v     = 1'b1;
                        n_end_pend = i_end_of_message;
                        n_padding  = 1'b0;
                    end else if (i_end_of_message) begin
                        n_state     = ST_PAD;
                        n_end_pend  = 1'b1;
                        n_padding   = 1'b1;
                        n_pad_first = 1'b1;
                        n_final     = 1'b0;
                    end
                end
            end
            ST_PAD: begin
                blk_shift_byte = 1'b1;
                shift_byte     = pad_byte;
                n_fill         = r_fill + 6'd1;
                n_pad_first    = 1'b0;
                if (r_pad_first) begin
                    // marker before the length field: length fits here
                    n_final = (r_fill < LEN_START);
                end
                if (r_fill == 6'd63) begin
                    n_state = ST_RND;
                    n_rnd   = '0;
                    load_v  = 1'b1;
                end
            end
            ST_RND: begin
                do_round = 1'b1;
                n_rnd    = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (!r_end_pend) begin
                    for (int i = 0; i < WORDS; i++) begin
                        n_hash[i] = sum[i];
                    end
                    n_state = ST_IDLE;
                end else if (!r_padding) begin
                    for (int i = 0; i < WORDS; i++) begin
                        n_hash[i] = sum[i];
                    end
                    n_padding   = 1'b1;
                    n_pad_first = 1'b1;
                    n_final     = 1'b0;
                    n_state     = ST_PAD;
                end else if (!r_final) begin
                    // marker block done, length goes in the next one
                    for (int i = 0; i < WORDS; i++) begin
                        n_hash[i] = sum[i];
                    end
                    n_final = 1'b1;
                    n_state = ST_PAD;
                end else if (!r_out_valid || i_ready) begin
                    // hand off digest, restart the chain
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    for (int i = 0; i < WORDS; i++) begin
                        n_hash[i] = init_hash(3'(i));
                    end
                    n_bits      = '0;
                    n_fill      = '0;
                    n_end_pend  = 1'b0;
                    n_padding   = 1'b0;
                    n_final     = 1'b0;
                    n_pad_first = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_rnd       <= '0;
            r_bits      <= '0;
            r_end_pend  <= 1'b0;
            r_padding   <= 1'b0;
            r_pad_first <= 1'b0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < WORDS; i++) begin
                r_hash[i] <= init_hash(3'(i));
            end
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_rnd       <= n_rnd;
            r_bits      <= n_bits;
            r_end_pend  <= n_end_pend;
            r_padding   <= n_padding;
            r_pad_first <= n_pad_first;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
            for (int i = 0; i < WORDS; i++) begin
                r_hash[i] <= n_hash[i];
            end
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (blk_shift_byte) begin
            r_blk <= {r_blk[BLK_BITS-9:0], shift_byte};
        end else if (do_round) begin
            r_blk <= {r_blk[BLK_BITS-33:0], w_new};
        end
        if (load_v) begin
            for (int i = 0; i < WORDS; i++) begin
                r_v[i] <= r_hash[i];
            end
        end else if (do_round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (out_load) begin
            for (int i = 0; i < WORDS; i++) begin
                r_dig[i] <= sum[i];
            end
        end
    end

    assign o_digest_word_0 = r_dig[0];
    assign o_digest_word_1 = r_dig[1];
    assign o_digest_word_2 = r_dig[2];
    assign o_digest_word_3 = r_dig[3];
    assign o_digest_word_4 = r_dig[4];
    assign o_digest_word_5 = r_dig[5];
    assign o_digest_word_6 = r_dig[6];
    assign o_digest_word_7 = r_dig[7];

    // Last round always hands over to the fold cycle
    a_rnd_to_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RND && r_rnd == 6'd63) |=> (r_state == ST_ADD))
        else $error("round 63 not followed by fold");

    // A filled pad block starts compression at round zero
    a_pad_to_rnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PAD && r_fill == 6'd63) |=> (r_state == ST_RND && r_rnd == 6'd0))
        else $error("pad block did not start compression");

    // The length-carrying block only exists once padding began
    a_final_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_final |-> (r_padding && r_end_pend))
        else $error("final flag outside padding");

    // A digest only appears out of the fold cycle
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_ADD && r_state == ST_IDLE))
        else $error("digest raised outside fold");

    // Idle never holds a pending message end
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_end_pend && !r_padding))
        else $error("stale end flag in idle");

endmodule
